// ----- rtl/grid_bfs_color_path_core_macros.svh -----
// Assertion helpers used by the RTL core.
`ifndef GRID_BFS_COLOR_PATH_CORE_MACROS_SVH
`define GRID_BFS_COLOR_PATH_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define GBCP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define GBCP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/gbcp_pkg.sv -----
package gbcp_pkg;
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = COL_W + ROW_W;
   localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
   localparam int CNT_W      = ADDR_W + 1;
   localparam int DIM_W      = 7;
   localparam int THR_W      = 18;
   localparam int PIX_W      = 24;
   localparam int CSR_IDX_W  = 3;

   // Request kinds
   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_SEARCH = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   // Neighbor directions, in search order
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_END_X   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_END_Y   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH  = 3'd6;

   localparam logic [THR_W-1:0] DEFAULT_THRESHOLD = 18'd80;
endpackage

// ----- rtl/gbcp_ram.sv -----
module gbcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/grid_bfs_color_path_core.sv -----
// Shortest color-connected path search on an RGB image held in on-chip RAM.
// req channel: tuser carries the request kind (load pixel, run search, read
// path point); tdata carries pixel coordinates, color and point index.
// rsp channel: exactly one transfer per request; tuser is the status flag,
// tdata the point read, the current path length and the end-reached flag.
// csr port: a single-cycle write of one of seven registers (image size,
// start, end, color threshold); write only while the block is idle.
// A load, an unknown request and a rejected read or search are answered
// from the idle state; a valid read first fetches the path point. A search
// first clears the visited map, then walks the queue; one RAM read port
// and one 8x8 squarer are shared by every step, one color channel per
// cycle. Path recovery walks the path twice, first counting, then filling.
// Only one request is in work at a time; req_tready is low meanwhile.
// A finished result sits in the output register; if rsp_tready is low, the
// block waits there and takes no new request until it is transferred.
// Reset (synchronous) restores register defaults, empties the path and
// drops any result in flight; pixel contents are kept.
`include "grid_bfs_color_path_core_macros.svh"

module grid_bfs_color_path_core (
   input  logic                          clock,
   input  logic                          reset,
   // pixel_x, pixel_y, red, green, blue, point_index
   input  logic [47:0]                   req_tdata,
   // req_type
   input  logic [1:0]                    req_tuser,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // point_x, point_y, path_count, end_reached, zero pad
   output logic [31:0]                   rsp_tdata,
   // status
   output logic                          rsp_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_we,
   input  logic [gbcp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbcp_pkg::THR_W-1:0]    csr_wdata
);
   import gbcp_pkg::*;

   typedef enum logic [16:0] {
      ST_IDLE  = 17'h00001,
      ST_READ  = 17'h00002,
      ST_CLEAR = 17'h00004,
      ST_SEED  = 17'h00008,
      ST_POP   = 17'h00010,
      ST_POPW  = 17'h00020,
      ST_CURW  = 17'h00040,
      ST_NB    = 17'h00080,
      ST_NBW   = 17'h00100,
      ST_DIST  = 17'h00200,
      ST_DEC   = 17'h00400,
      ST_ENDW  = 17'h00800,
      ST_CNT   = 17'h01000,
      ST_CNTW  = 17'h02000,
      ST_FILL  = 17'h04000,
      ST_FILLW = 17'h08000,
      ST_RESP  = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic [DIM_W-1:0] width_ff, height_ff;
   logic [COL_W-1:0] sx_ff, ex_ff;
   logic [ROW_W-1:0] sy_ff, ey_ff;
   logic [THR_W-1:0] thr_ff;

   // Search and path state
   logic [CNT_W-1:0]  path_len_ff, path_len_in;
   logic              reached_ff, reached_in;
   logic [CNT_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] cur_ff, cur_in, nb_ff, nb_in;
   logic [PIX_W-1:0]  cur_col_ff, cur_col_in, nb_col_ff, nb_col_in;
   logic [1:0]        dir_ff, dir_in, chan_ff, chan_in;
   logic [THR_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  len_ff, len_in, k_ff, k_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [COL_W-1:0]  rsp_x_ff, rsp_x_in;
   logic [ROW_W-1:0]  rsp_y_ff, rsp_y_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_reached_ff, rsp_reached_in;
   logic              res_status_ff, res_status_in;

   // RAM ports
   logic              pix_we, vis_we, vis_wd, pred_we, q_we, path_we;
   logic [ADDR_W-1:0] pix_wa, pix_ra, vis_wa, vis_ra, pred_wa, pred_ra;
   logic [ADDR_W-1:0] q_wa, q_ra, path_wa, path_ra, q_wd, path_wd;
   logic [PIX_W-1:0]  pix_wd, pix_rd;
   logic              vis_rd;
   logic [1:0]        pred_wd, pred_rd;
   logic [ADDR_W-1:0] q_rd, path_rd;

   gbcp_ram #(.WIDTH(PIX_W), .DEPTH(CELLS)) u_pix (
      .clock(clock), .we(pix_we), .waddr(pix_wa), .wdata(pix_wd),
      .raddr(pix_ra), .rdata(pix_rd));
   gbcp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis (
      .clock(clock), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
      .raddr(vis_ra), .rdata(vis_rd));
   gbcp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_pred (
      .clock(clock), .we(pred_we), .waddr(pred_wa), .wdata(pred_wd),
      .raddr(pred_ra), .rdata(pred_rd));
   gbcp_ram #(.WIDTH(ADDR_W), .DEPTH(CELLS)) u_queue (
      .clock(clock), .we(q_we), .waddr(q_wa), .wdata(q_wd),
      .raddr(q_ra), .rdata(q_rd));
   gbcp_ram #(.WIDTH(ADDR_W), .DEPTH(CELLS)) u_path (
      .clock(clock), .we(path_we), .waddr(path_wa), .wdata(path_wd),
      .raddr(path_ra), .rdata(path_rd));

   // Request fields
   logic [1:0]        req_kind;
   logic [COL_W-1:0]  req_x;
   logic [ROW_W-1:0]  req_y;
   logic [PIX_W-1:0]  req_rgb;
   logic [11:0]       req_idx;
   logic              req_xfer;

   assign req_kind = req_tuser;
   assign req_x    = req_tdata[5:0];
   assign req_y    = req_tdata[11:6];
   assign req_rgb  = {req_tdata[19:12], req_tdata[27:20], req_tdata[35:28]};
   assign req_idx  = req_tdata[47:36];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;

   // Image size saturated to 1..MAX
   logic [DIM_W-1:0] w_eff, h_eff;
   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) w_eff = DIM_W'(1);
      else if (width_ff > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
      h_eff = height_ff;
      if (height_ff == '0) h_eff = DIM_W'(1);
      else if (height_ff > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
   end

   logic [ADDR_W-1:0] s_addr, e_addr;
   logic              range_bad;
   assign s_addr = {sy_ff, sx_ff};
   assign e_addr = {ey_ff, ex_ff};
   assign range_bad = ({1'b0, sx_ff} >= w_eff) || ({1'b0, sy_ff} >= h_eff) ||
                      ({1'b0, ex_ff} >= w_eff) || ({1'b0, ey_ff} >= h_eff);

   // Neighbor of the current pixel in the current direction
   logic [COL_W-1:0]  cx;
   logic [ROW_W-1:0]  cy;
   logic              nb_ok;
   logic [ADDR_W-1:0] nb_addr;
   always_comb begin
      cx = cur_ff[COL_W-1:0];
      cy = cur_ff[ADDR_W-1:COL_W];
      nb_ok = 1'b0;
      nb_addr = cur_ff;
      case (dir_ff)
         DIR_UP: begin
            nb_ok = (cy != '0);
            nb_addr = {cy - ROW_W'(1), cx};
         end
         DIR_DOWN: begin
            nb_ok = (({1'b0, cy} + DIM_W'(1)) < h_eff);
            nb_addr = {cy + ROW_W'(1), cx};
         end
         DIR_LEFT: begin
            nb_ok = (cx != '0);
            nb_addr = {cy, cx - COL_W'(1)};
         end
         DIR_RIGHT: begin
            nb_ok = (({1'b0, cx} + DIM_W'(1)) < w_eff);
            nb_addr = {cy, cx + COL_W'(1)};
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   // Step one pixel back toward the start
   function automatic logic [ADDR_W-1:0] step_back(input logic [ADDR_W-1:0] c,
                                                   input logic [1:0] d);
      logic [ADDR_W-1:0] r;
      case (d)
         DIR_UP:   r = c + ADDR_W'(MAX_WIDTH);
         DIR_DOWN: r = c - ADDR_W'(MAX_WIDTH);
         DIR_LEFT: r = c + ADDR_W'(1);
         default:  r = c - ADDR_W'(1);
      endcase
      return r;
   endfunction

   // Shared squarer: one color channel per cycle
   logic [7:0]  ch_a, ch_b, ch_d;
   logic [15:0] ch_sq;
   always_comb begin
      case (chan_ff)
         2'd0: begin
            ch_a = cur_col_ff[23:16];
            ch_b = nb_col_ff[23:16];
         end
         2'd1: begin
            ch_a = cur_col_ff[15:8];
            ch_b = nb_col_ff[15:8];
         end
         default: begin
            ch_a = cur_col_ff[7:0];
            ch_b = nb_col_ff[7:0];
         end
      endcase
      ch_d  = (ch_a > ch_b) ? (ch_a - ch_b) : (ch_b - ch_a);
      ch_sq = ch_d * ch_d;
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      path_len_in    = path_len_ff;
      reached_in     = reached_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      clr_in         = clr_ff;
      cur_in         = cur_ff;
      nb_in          = nb_ff;
      cur_col_in     = cur_col_ff;
      nb_col_in      = nb_col_ff;
      dir_in         = dir_ff;
      chan_in        = chan_ff;
      acc_in         = acc_ff;
      len_in         = len_ff;
      k_in           = k_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_reached_in = rsp_reached_ff;

      pix_we  = 1'b0; pix_wa  = {req_y, req_x}; pix_wd = req_rgb; pix_ra = nb_addr;
      vis_we  = 1'b0; vis_wa  = clr_ff; vis_wd = 1'b0; vis_ra = nb_addr;
      pred_we = 1'b0; pred_wa = nb_ff; pred_wd = dir_ff; pred_ra = cur_ff;
      q_we    = 1'b0; q_wa    = tail_ff[ADDR_W-1:0]; q_wd = nb_ff;
      q_ra    = head_ff[ADDR_W-1:0];
      path_we = 1'b0; path_wa = k_ff[ADDR_W-1:0] - ADDR_W'(1); path_wd = cur_ff;
      path_ra = req_idx[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               rsp_x_in       = '0;
               rsp_y_in       = '0;
               rsp_count_in   = path_len_ff;
               rsp_reached_in = reached_ff;
               case (req_kind)
                  REQ_LOAD: begin
                     // Coordinates always lie inside the store
                     pix_we        = 1'b1;
                     rsp_status_in = 1'b0;
                     rsp_valid_in  = 1'b1;
                  end
                  REQ_SEARCH: begin
                     path_len_in = '0;
                     reached_in  = 1'b0;
                     if (range_bad) begin
                        rsp_status_in  = 1'b1;
                        rsp_count_in   = '0;
                        rsp_reached_in = 1'b0;
                        rsp_valid_in   = 1'b1;
                     end else begin
                        clr_in   = '0;
                        state_in = ST_CLEAR;
                     end
                  end
                  REQ_READ: begin
                     if ({1'b0, req_idx} < path_len_ff) begin
                        state_in = ST_READ;
                     end else begin
                        rsp_status_in = 1'b1;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  default: begin
                     rsp_status_in = 1'b1;
                     rsp_valid_in  = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_status_in = 1'b0;
            cur_in        = path_rd;
            state_in      = ST_RESP;
         end
         ST_CLEAR: begin
            vis_we = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(CELLS - 1)) state_in = ST_SEED;
         end
         ST_SEED: begin
            vis_we  = 1'b1;
            vis_wa  = s_addr;
            vis_wd  = 1'b1;
            q_we    = 1'b1;
            q_wa    = '0;
            q_wd    = s_addr;
            head_in = '0;
            tail_in = CNT_W'(1);
            state_in = ST_POP;
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               vis_ra   = e_addr;
               state_in = ST_ENDW;
            end else begin
               head_in  = head_ff + CNT_W'(1);
               state_in = ST_POPW;
            end
         end
         ST_POPW: begin
            cur_in   = q_rd;
            pix_ra   = q_rd;
            state_in = ST_CURW;
         end
         ST_CURW: begin
            cur_col_in = pix_rd;
            dir_in     = DIR_UP;
            state_in   = ST_NB;
         end
         ST_NB: begin
            if (nb_ok) begin
               nb_in    = nb_addr;
               state_in = ST_NBW;
            end else if (dir_ff == DIR_RIGHT) begin
               state_in = ST_POP;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         ST_NBW: begin
            nb_col_in = pix_rd;
            acc_in    = '0;
            chan_in   = 2'd0;
            if (!vis_rd) begin
               state_in = ST_DIST;
            end else if (dir_ff == DIR_RIGHT) begin
               state_in = ST_POP;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = ST_NB;
            end
         end
         ST_DIST: begin
            acc_in  = acc_ff + THR_W'(ch_sq);
            chan_in = chan_ff + 2'd1;
            if (chan_ff == 2'd2) state_in = ST_DEC;
         end
         ST_DEC: begin
            if (acc_ff <= thr_ff) begin
               vis_we  = 1'b1;
               vis_wa  = nb_ff;
               vis_wd  = 1'b1;
               pred_we = 1'b1;
               if (tail_ff < CNT_W'(CELLS)) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + CNT_W'(1);
               end
            end
            if (dir_ff == DIR_RIGHT) begin
               state_in = ST_POP;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = ST_NB;
            end
         end
         ST_ENDW: begin
            if (!vis_rd) begin
               // End not reached: path is the start alone
               path_we       = 1'b1;
               path_wa       = '0;
               path_wd       = s_addr;
               path_len_in   = CNT_W'(1);
               reached_in    = 1'b0;
               res_status_in = 1'b0;
               cur_in        = '0;
               state_in      = ST_RESP;
            end else begin
               reached_in = 1'b1;
               len_in     = CNT_W'(1);
               cur_in     = e_addr;
               state_in   = ST_CNT;
            end
         end
         ST_CNT: begin
            if (cur_ff == s_addr || len_ff >= CNT_W'(CELLS)) begin
               k_in     = len_ff;
               cur_in   = e_addr;
               state_in = ST_FILL;
            end else begin
               state_in = ST_CNTW;
            end
         end
         ST_CNTW: begin
            cur_in   = step_back(cur_ff, pred_rd);
            len_in   = len_ff + CNT_W'(1);
            state_in = ST_CNT;
         end
         ST_FILL: begin
            path_we = 1'b1;
            if (cur_ff == s_addr) begin
               path_len_in   = len_ff;
               res_status_in = 1'b0;
               cur_in        = '0;
               state_in      = ST_RESP;
            end else begin
               state_in = ST_FILLW;
            end
         end
         ST_FILLW: begin
            cur_in = step_back(cur_ff, pred_rd);
            k_in   = k_ff - CNT_W'(1);
            if (k_ff == CNT_W'(1)) begin
               path_len_in   = len_ff;
               res_status_in = 1'b0;
               cur_in        = '0;
               state_in      = ST_RESP;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_RESP: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_x_in       = cur_ff[COL_W-1:0];
               rsp_y_in       = cur_ff[ADDR_W-1:COL_W];
               rsp_count_in   = path_len_ff;
               rsp_reached_in = reached_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         path_len_ff  <= '0;
         reached_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         path_len_ff  <= path_len_in;
         reached_ff   <= reached_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      clr_ff         <= clr_in;
      cur_ff         <= cur_in;
      nb_ff          <= nb_in;
      cur_col_ff     <= cur_col_in;
      nb_col_ff      <= nb_col_in;
      dir_ff         <= dir_in;
      chan_ff        <= chan_in;
      acc_ff         <= acc_in;
      len_ff         <= len_in;
      k_ff           <= k_in;
      res_status_ff  <= res_status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_reached_ff <= rsp_reached_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(MAX_WIDTH);
         height_ff <= DIM_W'(MAX_HEIGHT);
         sx_ff     <= '0;
         sy_ff     <= '0;
         ex_ff     <= '0;
         ey_ff     <= '0;
         thr_ff    <= DEFAULT_THRESHOLD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:   width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT:  height_ff <= csr_wdata[DIM_W-1:0];
            CSR_START_X: sx_ff     <= csr_wdata[COL_W-1:0];
            CSR_START_Y: sy_ff     <= csr_wdata[ROW_W-1:0];
            CSR_END_X:   ex_ff     <= csr_wdata[COL_W-1:0];
            CSR_END_Y:   ey_ff     <= csr_wdata[ROW_W-1:0];
            CSR_THRESH:  thr_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_reached_ff, rsp_count_ff, rsp_y_ff, rsp_x_ff};

   `GBCP_ASSERT_IMP(a_ready_idle, clock, reset, req_tready, state_ff == ST_IDLE, "ready outside idle")
   `GBCP_ASSERT_IMP(a_queue_order, clock, reset, 1'b1, head_ff <= tail_ff, "queue head passed tail")
   `GBCP_ASSERT_IMP(a_reached_len, clock, reset, reached_ff && state_ff == ST_IDLE, path_len_ff != '0, "reached with empty path")
   `GBCP_ASSERT_NXT(a_search_busy, clock, reset, req_xfer && req_kind == REQ_SEARCH && !range_bad, !req_tready, "search did not stall input")
endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import gbcp_pkg::*;

   // request code with no meaning, and a register index past the list
   localparam logic [1:0]           REQ_BAD    = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int                   LONG_HOLD  = 400;

   typedef struct packed {
      logic        status;
      logic [5:0]  point_x;
      logic [5:0]  point_y;
      logic [12:0] path_count;
      logic        end_reached;
   } path_answer_type;

   logic                 clock;
   logic                 reset;
   logic [47:0]          req_tdata;
   logic [1:0]           req_tuser;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [31:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [THR_W-1:0]     csr_wdata;

   grid_bfs_color_path_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // shadow of the block: registers, image and last path
   logic [6:0]       width_reg;
   logic [6:0]       height_reg;
   logic [5:0]       start_col, start_row, end_col, end_row;
   logic [THR_W-1:0] thresh_reg;
   logic [PIX_W-1:0] image_mem [CELLS];
   bit               pixel_loaded [CELLS];
   bit               seen [CELLS];
   logic [1:0]       came_from [CELLS];
   int               walk_queue [CELLS];
   int               path_pts [$];
   bit               end_hit;

   path_answer_type  pending_answers [$];
   int               error_count;
   int               items_sent;
   int               searches_done;
   int               searches_reached;
   int               reads_ok;
   int               next_gap;
   bit               burst_mode;
   bit               rsp_no_stall;
   int               rsp_hold_req;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int clamp_dim(logic [6:0] v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return v;
   endfunction

   function automatic int color_dist(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      int dr, dg, db;
      dr = int'(a[23:16]) - int'(b[23:16]);
      dg = int'(a[15:8]) - int'(b[15:8]);
      db = int'(a[7:0]) - int'(b[7:0]);
      return dr * dr + dg * dg + db * db;
   endfunction

   // breadth-first walk over the shadow image; returns the status bit
   function automatic logic walk_image();
      int w, h, s, e, head, tail, c, cx, cy, nx, ny, n, d, cur;
      bit ok;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      path_pts.delete();
      end_hit = 1'b0;
      if (start_col >= w || start_row >= h || end_col >= w || end_row >= h) return 1'b1;
      foreach (seen[i]) seen[i] = 1'b0;
      s = start_row * MAX_WIDTH + start_col;
      e = end_row * MAX_WIDTH + end_col;
      seen[s] = 1'b1;
      walk_queue[0] = s;
      head = 0;
      tail = 1;
      while (head < tail) begin
         c = walk_queue[head];
         head++;
         cx = c % MAX_WIDTH;
         cy = c / MAX_WIDTH;
         for (d = 0; d < 4; d++) begin
            nx = cx;
            ny = cy;
            ok = 1'b1;
            if (d == DIR_UP) begin
               if (cy == 0) ok = 1'b0; else ny = cy - 1;
            end else if (d == DIR_DOWN) begin
               if (cy + 1 >= h) ok = 1'b0; else ny = cy + 1;
            end else if (d == DIR_LEFT) begin
               if (cx == 0) ok = 1'b0; else nx = cx - 1;
            end else begin
               if (cx + 1 >= w) ok = 1'b0; else nx = cx + 1;
            end
            n = ny * MAX_WIDTH + nx;
            if (ok && !seen[n] && color_dist(image_mem[c], image_mem[n]) <= thresh_reg) begin
               seen[n] = 1'b1;
               came_from[n] = d[1:0];
               walk_queue[tail] = n;
               tail++;
            end
         end
      end
      if (!seen[e]) begin
         path_pts.push_front(s);
         return 1'b0;
      end
      // follow predecessors back from the end
      end_hit = 1'b1;
      cur = e;
      path_pts.push_front(cur);
      while (cur != s) begin
         case (came_from[cur])
            DIR_UP:   cur += MAX_WIDTH;
            DIR_DOWN: cur -= MAX_WIDTH;
            DIR_LEFT: cur += 1;
            default:  cur -= 1;
         endcase
         path_pts.push_front(cur);
      end
      return 1'b0;
   endfunction

   function automatic path_answer_type answer_request(logic [1:0] kind, int x, int y,
                                                      logic [PIX_W-1:0] rgb, int idx);
      path_answer_type a;
      a = '0;
      case (kind)
         REQ_LOAD: begin
            image_mem[y * MAX_WIDTH + x] = rgb;
            pixel_loaded[y * MAX_WIDTH + x] = 1'b1;
         end
         REQ_SEARCH: begin
            a.status = walk_image();
            searches_done++;
            if (end_hit) searches_reached++;
         end
         REQ_READ: begin
            if (idx < path_pts.size()) begin
               a.point_x = 6'(path_pts[idx] % MAX_WIDTH);
               a.point_y = 6'(path_pts[idx] / MAX_WIDTH);
               reads_ok++;
            end else begin
               a.status = 1'b1;
            end
         end
         default: a.status = 1'b1;
      endcase
      a.path_count = 13'(path_pts.size());
      a.end_reached = end_hit;
      return a;
   endfunction

   // offer one request and wait for its transfer
   task automatic send_item(logic [1:0] kind, int x, int y, logic [PIX_W-1:0] rgb, int idx);
      repeat (next_gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {idx[11:0], rgb[7:0], rgb[15:8], rgb[23:16], y[5:0], x[5:0]};
      do @(posedge clock); while (!req_tready);
      pending_answers.insert(pending_answers.size(), answer_request(kind, x, y, rgb, idx));
      items_sent++;
      next_gap = burst_mode ? 0 : $urandom_range(0, 9);
      if (next_gap > 0) req_tvalid <= 1'b0;
   endtask

   // drop valid and wait until every answer is back
   task automatic wait_idle();
      // valid is already low when the last transfer drew a gap
      if (next_gap == 0) req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [THR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_WIDTH:   width_reg  = val[6:0];
         CSR_HEIGHT:  height_reg = val[6:0];
         CSR_START_X: start_col  = val[5:0];
         CSR_START_Y: start_row  = val[5:0];
         CSR_END_X:   end_col    = val[5:0];
         CSR_END_Y:   end_row    = val[5:0];
         CSR_THRESH:  thresh_reg = val;
         default: ;
      endcase
   endtask

   task automatic set_search(int w, int h, int sx, int sy, int ex, int ey, int thr);
      // junk in the unused upper bits must be dropped
      write_reg(CSR_WIDTH, THR_W'(w));
      write_reg(CSR_HEIGHT, THR_W'(h));
      write_reg(CSR_START_X, {12'($urandom_range(0, 4095)), sx[5:0]});
      write_reg(CSR_START_Y, {12'($urandom_range(0, 4095)), sy[5:0]});
      write_reg(CSR_END_X, {12'($urandom_range(0, 4095)), ex[5:0]});
      write_reg(CSR_END_Y, {12'($urandom_range(0, 4095)), ey[5:0]});
      write_reg(CSR_THRESH, THR_W'(thr));
   endtask

   function automatic logic [PIX_W-1:0] near_color(logic [PIX_W-1:0] base);
      logic [PIX_W-1:0] c;
      int v;
      if ($urandom_range(0, 4) == 0) return PIX_W'($urandom);
      for (int k = 0; k < 3; k++) begin
         v = int'(base[k*8 +: 8]) + $urandom_range(0, 8);
         c[k*8 +: 8] = (v > 255) ? 8'd255 : v[7:0];
      end
      return c;
   endfunction

   // load the image in use; always covers pixels never written
   task automatic fill_image(bit refill);
      logic [PIX_W-1:0] base;
      base = PIX_W'($urandom);
      for (int y = 0; y < clamp_dim(height_reg); y++)
         for (int x = 0; x < clamp_dim(width_reg); x++)
            if (refill || !pixel_loaded[y * MAX_WIDTH + x])
               send_item(REQ_LOAD, x, y, near_color(base), 0);
   endtask

   task automatic read_path(int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 5) == 0)
            send_item(REQ_READ, 0, 0, 0, $urandom_range(0, 4095));
         else
            send_item(REQ_READ, 0, 0, 0, $urandom_range(0, path_pts.size()));
      end
   endtask

   // check each result transfer against the oldest expectation
   initial begin
      int hold;
      path_answer_type want;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_answers.size() == 0) begin
               $error("result transfer with nothing expected");
               error_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[5:0] !== want.point_x) begin
                  $error("point_x: expected %0d, got %0d", want.point_x, rsp_tdata[5:0]);
                  error_count++;
               end
               if (rsp_tdata[11:6] !== want.point_y) begin
                  $error("point_y: expected %0d, got %0d", want.point_y, rsp_tdata[11:6]);
                  error_count++;
               end
               if (rsp_tdata[24:12] !== want.path_count) begin
                  $error("path_count: expected %0d, got %0d", want.path_count,
                         rsp_tdata[24:12]);
                  error_count++;
               end
               if (rsp_tdata[25] !== want.end_reached) begin
                  $error("end_reached: expected %0d, got %0d", want.end_reached,
                         rsp_tdata[25]);
                  error_count++;
               end
            end
            hold = rsp_no_stall ? 0 : $urandom_range(0, 9);
         end
         if (rsp_hold_req > 0) begin
            hold = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic test_empty_path();
      send_item(REQ_READ, 0, 0, 0, 0);
      send_item(REQ_BAD, 63, 63, 24'hFFFFFF, 4095);
      wait_idle();
      write_reg(CSR_UNUSED, '1);
   endtask

   task automatic test_small_grid();
      set_search(3, 2, 0, 0, 2, 1, 195075);
      send_item(REQ_LOAD, 63, 63, 24'hFFFFFF, 4095);
      send_item(REQ_LOAD, 0, 0, 24'h000000, 0);
      send_item(REQ_LOAD, 1, 0, 24'hFF0000, 0);
      send_item(REQ_LOAD, 2, 0, 24'h00FF00, 0);
      send_item(REQ_LOAD, 0, 1, 24'h0000FF, 0);
      send_item(REQ_LOAD, 1, 1, 24'h000000, 0);
      send_item(REQ_LOAD, 2, 1, 24'hFFFFFF, 0);
      send_item(REQ_SEARCH, 0, 0, 0, 0);
      for (int k = 0; k < 5; k++) send_item(REQ_READ, 0, 0, 0, k);
      send_item(REQ_READ, 0, 0, 0, 4095);
      wait_idle();
   endtask

   task automatic test_special_cases();
      // start equals end
      set_search(3, 2, 1, 1, 1, 1, 0);
      send_item(REQ_SEARCH, 0, 0, 0, 0);
      send_item(REQ_READ, 0, 0, 0, 0);
      wait_idle();
      // end out of reach at threshold zero
      set_search(3, 2, 0, 0, 2, 0, 0);
      send_item(REQ_SEARCH, 0, 0, 0, 0);
      send_item(REQ_READ, 0, 0, 0, 1);
      wait_idle();
      // start outside the image
      set_search(3, 2, 5, 0, 0, 0, 80);
      send_item(REQ_SEARCH, 0, 0, 0, 0);
      send_item(REQ_READ, 0, 0, 0, 0);
      wait_idle();
      // zero width saturates to one column
      set_search(0, 2, 0, 0, 0, 1, 262143);
      send_item(REQ_SEARCH, 0, 0, 0, 0);
      send_item(REQ_READ, 0, 0, 0, 1);
      wait_idle();
   endtask

   task automatic test_backpressure();
      // receiver holds off while reads keep coming
      rsp_hold_req = LONG_HOLD;
      for (int k = 0; k < 8; k++) send_item(REQ_READ, 0, 0, 0, k % 3);
      wait_idle();
      // back-to-back transfers with no stall on either side
      burst_mode = 1'b1;
      rsp_no_stall = 1'b1;
      next_gap = 0;
      fill_image(1'b1);
      send_item(REQ_SEARCH, 0, 0, 0, 0);
      read_path(10);
      wait_idle();
      burst_mode = 1'b0;
      rsp_no_stall = 1'b0;
   endtask

   task automatic test_random();
      int shape, w, h, wi, hi, sx, sy, ex, ey, thr, pick;
      while (items_sent < 1200) begin
         wait_idle();
         shape = $urandom_range(0, 15);
         if (shape == 0) begin
            w = $urandom_range(0, 1) ? 127 : 64;
            h = $urandom_range(1, 2);
         end else if (shape == 1) begin
            w = $urandom_range(1, 2);
            h = $urandom_range(0, 1) ? 127 : 64;
         end else begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
         end
         wi = clamp_dim(w);
         hi = clamp_dim(h);
         sx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, wi - 1);
         sy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, hi - 1);
         ex = $urandom_range(0, wi - 1);
         ey = $urandom_range(0, hi - 1);
         if ($urandom_range(0, 9) == 0) begin
            ex = sx;
            ey = sy;
         end
         pick = $urandom_range(0, 7);
         case (pick)
            0: thr = 0;
            1: thr = 195075;
            2: thr = 262143;
            3: thr = $urandom_range(0, 3000);
            default: thr = $urandom_range(0, 300);
         endcase
         set_search(w, h, sx, sy, ex, ey, thr);
         fill_image($urandom_range(0, 3) != 0);
         // stray loads anywhere in the store, and a bad request now and then
         repeat ($urandom_range(0, 3))
            send_item(REQ_LOAD, $urandom_range(0, 63), $urandom_range(0, 63), PIX_W'($urandom),
                      $urandom_range(0, 4095));
         if ($urandom_range(0, 5) == 0)
            send_item(REQ_BAD, $urandom_range(0, 63), $urandom_range(0, 63), PIX_W'($urandom),
                      $urandom_range(0, 4095));
         send_item(REQ_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63), PIX_W'($urandom),
                   $urandom_range(0, 4095));
         read_path($urandom_range(3, 8));
      end
      wait_idle();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = REQ_LOAD;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_WIDTH;
      csr_wdata  = '0;
      width_reg  = 7'd64;
      height_reg = 7'd64;
      start_col  = '0;
      start_row  = '0;
      end_col    = '0;
      end_row    = '0;
      thresh_reg = DEFAULT_THRESHOLD;
      end_hit    = 1'b0;
      error_count = 0;
      items_sent = 0;
      searches_done = 0;
      searches_reached = 0;
      reads_ok = 0;
      next_gap = 0;
      burst_mode = 1'b0;
      rsp_no_stall = 1'b0;
      rsp_hold_req = 0;
      foreach (pixel_loaded[i]) pixel_loaded[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_path();
      test_small_grid();
      test_special_cases();
      test_backpressure();
      test_random();

      repeat (20) @(posedge clock);
      $display("Sent %0d requests: %0d searches (%0d reached the end), %0d path points read.",
               items_sent, searches_done, searches_reached, reads_ok);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
